// ===== design/integer_to_ascii_digits_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for integer_to_ascii_digits
// Concurrent checks that compile out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_DIGITS_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every edge outside reset.
`define I2A_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, checked on every edge outside reset.
`define I2A_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define I2A_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define I2A_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/i2a_pkg.sv =====
// ---------------------------------------------------------------------------
// i2a_pkg
// Shared constants, codes and helpers of the integer to ASCII converter.
// ---------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MODE_W         = 2;
  localparam int CHAR_W         = 7;

  // Mode codes; bit 1 selects hexadecimal, so the last code acts as hex too
  localparam logic [MODE_W-1:0] MODE_SDEC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UDEC    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HEX_ALT = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A_LOW = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [3:0]        DEC_BASE   = 4'd10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_TRIM,
    S_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {3'b000, d};
    if (d < DEC_BASE) begin
      ascii_of = CHAR_ZERO + dx;
    end else begin
      ascii_of = CHAR_A_LOW + dx - {3'b000, DEC_BASE};
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/i2a_if.sv =====
// ---------------------------------------------------------------------------
// i2a_num_if / i2a_text_if
// Valid/ready channels: numbers in, characters out.
// ---------------------------------------------------------------------------
`default_nettype none

interface i2a_num_if #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [i2a_pkg::MODE_W-1:0]  mode;
  logic [VALUE_BITS-1:0]       value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface i2a_text_if;
  logic                        valid;
  logic                        ready;
  logic [i2a_pkg::CHAR_W-1:0]  character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== design/integer_to_ascii_digits.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_digits
// Prints one value as ASCII decimal (signed or unsigned) or lower-case hex.
// ---------------------------------------------------------------------------
// One number is taken at a time. The value's magnitude is shifted in one bit
// per cycle into a digit register (shift-and-add-3 for decimal, plain shift
// for hex). Leading zero digits are then dropped one per cycle, DIGITS - n
// drops for n digits with DIGITS = (VALUE_BITS+2)/3+1, and the first digit to
// print is then found. The characters go out one per cycle through an output
// register while the character side accepts them, minus sign first for a
// negative signed value. The next number is accepted once the last character
// sits in the output register.
`default_nettype none
`include "integer_to_ascii_digits_assert.svh"

module integer_to_ascii_digits #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  i2a_num_if.sink    number,
  i2a_text_if.source text
);

  localparam int DIGITS = (VALUE_BITS + 2) / 3 + 1;
  localparam int DW     = DIGITS * 4;
  localparam int CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DCNT_W = $clog2(DIGITS + 1);

  i2a_pkg::state_t             state, state_next;
  logic [VALUE_BITS-1:0]       val, val_next;
  logic [DW-1:0]               digits, digits_next;
  logic [CNT_W-1:0]            bit_cnt, bit_cnt_next;
  logic [DCNT_W-1:0]           dcnt, dcnt_next;
  logic                        neg, neg_next;
  logic                        hex, hex_next;
  logic                        o_valid, o_valid_next;
  logic [i2a_pkg::CHAR_W-1:0]  o_char, o_char_next;
  logic                        o_last, o_last_next;

  logic [DW-1:0]               adj;
  logic [3:0]                  top;
  logic                        load;
  logic                        accept;

  assign top    = digits[DW-1 -: 4];
  assign load   = !o_valid || text.ready;
  assign accept = number.valid && number.ready;

  // Add 3 to every decimal digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (!hex && (digits[i*4 +: 4] >= 4'd5)) begin
        adj[i*4 +: 4] = digits[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = digits[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_next   = state;
    val_next     = val;
    digits_next  = digits;
    bit_cnt_next = bit_cnt;
    dcnt_next    = dcnt;
    neg_next     = neg;
    hex_next     = hex;
    o_valid_next = o_valid && !text.ready;
    o_char_next  = o_char;
    o_last_next  = o_last;

    unique case (state)
      i2a_pkg::S_IDLE: begin
        if (accept) begin
          neg_next = (number.mode == i2a_pkg::MODE_SDEC) && number.value[VALUE_BITS-1];
          hex_next = (number.mode == i2a_pkg::MODE_HEX) ||
                     (number.mode == i2a_pkg::MODE_HEX_ALT);
          val_next     = neg_next ? (~number.value + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                                  : number.value;
          digits_next  = '0;
          bit_cnt_next = '0;
          state_next   = i2a_pkg::S_CONV;
        end
      end
      i2a_pkg::S_CONV: begin
        digits_next  = {adj[DW-2:0], val[VALUE_BITS-1]};
        val_next     = val << 1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == CNT_W'(VALUE_BITS - 1)) begin
          dcnt_next  = DCNT_W'(DIGITS);
          state_next = i2a_pkg::S_TRIM;
        end
      end
      i2a_pkg::S_TRIM: begin
        // Drop leading zeros but keep one digit so that zero prints
        if ((top == 4'd0) && (dcnt != DCNT_W'(1))) begin
          digits_next = digits << 4;
          dcnt_next   = dcnt - 1'b1;
        end else begin
          state_next = i2a_pkg::S_EMIT;
        end
      end
      i2a_pkg::S_EMIT: begin
        if (load) begin
          o_valid_next = 1'b1;
          if (neg) begin
            o_char_next = i2a_pkg::CHAR_MINUS;
            o_last_next = 1'b0;
            neg_next    = 1'b0;
          end else begin
            o_char_next = i2a_pkg::ascii_of(top);
            o_last_next = (dcnt == DCNT_W'(1));
            digits_next = digits << 4;
            dcnt_next   = dcnt - 1'b1;
            if (dcnt == DCNT_W'(1)) begin
              state_next = i2a_pkg::S_IDLE;
            end
          end
        end
      end
      default: state_next = i2a_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= i2a_pkg::S_IDLE;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      o_valid <= o_valid_next;
    end
    val     <= val_next;
    digits  <= digits_next;
    bit_cnt <= bit_cnt_next;
    dcnt    <= dcnt_next;
    neg     <= neg_next;
    hex     <= hex_next;
    o_char  <= o_char_next;
    o_last  <= o_last_next;
  end

  assign number.ready   = (state == i2a_pkg::S_IDLE);
  assign text.valid     = o_valid;
  assign text.character = o_char;
  assign text.last      = o_last;

  `I2A_ASSERT_NEXT(a_accept_starts_conv, clk, rst, accept, state == i2a_pkg::S_CONV)
  `I2A_ASSERT_IMPLY(a_mid_text_busy, clk, rst, text.valid && !text.last, state != i2a_pkg::S_IDLE)
  `I2A_ASSERT_IMPLY(a_emit_has_digit, clk, rst, state == i2a_pkg::S_EMIT, dcnt != '0)
  `I2A_ASSERT_NEXT(a_last_char_idle, clk, rst,
    (state == i2a_pkg::S_EMIT) && load && !neg && (dcnt == DCNT_W'(1)),
    (state == i2a_pkg::S_IDLE) && text.valid && text.last)

endmodule

`default_nettype wire
